### design/che_pkg.sv
// Shared types and constants of the color histogram engine.
// No dependencies; imported by the front, back and top level.
package che_pkg;

  // Command codes carried on func_i
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  // Channel count settings that enable counting
  localparam logic [2:0] CHAN_GRAY = 3'd1;
  localparam logic [2:0] CHAN_RGB  = 3'd3;
  localparam logic [2:0] CHAN_RESET = CHAN_GRAY;

  localparam int SAMPLE_W = 16;
  localparam int SEL_W    = 8;
  localparam int RESULT_W = 32;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_ADD_GRAY = 3'd1,
    OP_ADD_RGB  = 3'd2,
    OP_READ     = 3'd3,
    OP_CLEAR    = 3'd4
  } che_op_e;

  typedef struct packed {
    che_op_e op;
    logic    last;
    logic    sel_ok;
  } che_ctrl_t;

endpackage

### design/che_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module che_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/che_fifo.sv
// Small register queue between the front and back of the histogram engine.
// No dependencies.
module che_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/che_front.sv
// Front end: holds the channel count register, decodes commands and maps samples to bins.
// Depends on che_pkg.
module che_front #(
  parameter int BIN_COUNT        = 256,
  parameter int SAMPLE_FRAC_BITS = 12,
  localparam int BinW = $clog2(BIN_COUNT)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [2:0]                       cfg_data_i,
  input  logic [1:0]                       func_i,
  input  logic signed [che_pkg::SAMPLE_W-1:0] sample_gray_or_red_i,
  input  logic signed [che_pkg::SAMPLE_W-1:0] sample_green_i,
  input  logic signed [che_pkg::SAMPLE_W-1:0] sample_blue_i,
  input  logic [che_pkg::SEL_W-1:0]        bin_select_i,
  input  logic                             last_pixel_i,
  output che_pkg::che_ctrl_t               ctrl_o,
  output logic [BinW-1:0]                  bin_r_o,
  output logic [BinW-1:0]                  bin_g_o,
  output logic [BinW-1:0]                  bin_b_o
);
  import che_pkg::*;

  localparam int ProdW = SAMPLE_W + BinW + 1;
  localparam logic signed [ProdW-1:0] BinMaxS = ProdW'(BIN_COUNT - 1);
  localparam logic [ProdW-1:0] BinMaxU = ProdW'(BIN_COUNT - 1);

  logic [2:0] chan_q;

  // floor(s * (BIN_COUNT-1) / 2^FRAC), clamped to the bin range
  function automatic logic [BinW-1:0] to_bin(input logic signed [SAMPLE_W-1:0] s);
    logic signed [ProdW-1:0] prod;
    logic [ProdW-1:0]        shifted;
    logic [BinW-1:0]         bin;
    prod    = ProdW'(s) * BinMaxS;
    shifted = ProdW'(prod) >> SAMPLE_FRAC_BITS;
    if (prod <= 0) begin
      bin = '0;
    end else if (shifted > BinMaxU) begin
      bin = BinMaxU[BinW-1:0];
    end else begin
      bin = shifted[BinW-1:0];
    end
    return bin;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= CHAN_RESET;
    end else if (cfg_valid_i) begin
      chan_q <= cfg_data_i;
    end
  end

  always_comb begin
    ctrl_o.op     = OP_NOP;
    ctrl_o.last   = last_pixel_i;
    ctrl_o.sel_ok = (32'(bin_select_i) < BIN_COUNT);
    bin_r_o       = to_bin(sample_gray_or_red_i);
    bin_g_o       = to_bin(sample_green_i);
    bin_b_o       = to_bin(sample_blue_i);
    case (func_i)
      FUNC_ADD: begin
        if (chan_q == CHAN_GRAY) begin
          ctrl_o.op = OP_ADD_GRAY;
        end else if (chan_q == CHAN_RGB) begin
          ctrl_o.op = OP_ADD_RGB;
        end
      end
      FUNC_READ: begin
        ctrl_o.op = OP_READ;
        bin_r_o   = BinW'(bin_select_i);
        bin_g_o   = BinW'(bin_select_i);
        bin_b_o   = BinW'(bin_select_i);
      end
      FUNC_CLEAR: ctrl_o.op = OP_CLEAR;
      default:    ctrl_o.op = OP_NOP;
    endcase
  end

endmodule

### design/che_back.sv
// Back end: runs queued operations against the four bin banks and the totals.
// Depends on che_pkg and che_ram.
module che_back #(
  parameter int BIN_COUNT   = 256,
  parameter int COUNT_WIDTH = 32,
  localparam int BinW = $clog2(BIN_COUNT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  che_pkg::che_ctrl_t            ctrl_i,
  input  logic [BinW-1:0]               bin_r_i,
  input  logic [BinW-1:0]               bin_g_i,
  input  logic [BinW-1:0]               bin_b_i,
  output logic                          pop_o,
  output logic                          done_o,
  output logic [che_pkg::RESULT_W-1:0]  gray_count_o,
  output logic [che_pkg::RESULT_W-1:0]  red_count_o,
  output logic [che_pkg::RESULT_W-1:0]  green_count_o,
  output logic [che_pkg::RESULT_W-1:0]  blue_count_o,
  output logic [che_pkg::RESULT_W-1:0]  pixels_counted_o,
  output logic [che_pkg::RESULT_W-1:0]  images_counted_o
);
  import che_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE      = 4'b0001,
    S_WAIT_ADD  = 4'b0010,
    S_WAIT_READ = 4'b0100,
    S_SWEEP     = 4'b1000
  } state_e;

  localparam logic [BinW-1:0] LastBin = BinW'(BIN_COUNT - 1);

  state_e state_q, state_d;
  che_op_e op_q, op_d;
  logic last_q, last_d, sel_ok_q, sel_ok_d;
  logic [BinW-1:0] bin_r_q, bin_r_d, bin_g_q, bin_g_d, bin_b_q, bin_b_d;
  logic [BinW-1:0] sweep_q, sweep_d;
  logic report_q, report_d;
  logic [COUNT_WIDTH-1:0] pixel_q, pixel_d, image_q, image_d;

  logic done_q, done_d;
  logic [RESULT_W-1:0] gray_q, gray_d, red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [RESULT_W-1:0] pix_res_q, pix_res_d, img_res_q, img_res_d;

  logic we_gray, we_red, we_green, we_blue;
  logic [BinW-1:0] wa_gray, wa_red, wa_green, wa_blue;
  logic [COUNT_WIDTH-1:0] wd_gray, wd_red, wd_green, wd_blue;
  logic [COUNT_WIDTH-1:0] rd_gray, rd_red, rd_green, rd_blue;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  che_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BIN_COUNT)) u_gray_bank (
    .clk_i, .we_i(we_gray), .waddr_i(wa_gray), .wdata_i(wd_gray),
    .raddr_i(bin_r_i), .rdata_o(rd_gray)
  );
  che_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BIN_COUNT)) u_red_bank (
    .clk_i, .we_i(we_red), .waddr_i(wa_red), .wdata_i(wd_red),
    .raddr_i(bin_r_i), .rdata_o(rd_red)
  );
  che_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BIN_COUNT)) u_green_bank (
    .clk_i, .we_i(we_green), .waddr_i(wa_green), .wdata_i(wd_green),
    .raddr_i(bin_g_i), .rdata_o(rd_green)
  );
  che_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BIN_COUNT)) u_blue_bank (
    .clk_i, .we_i(we_blue), .waddr_i(wa_blue), .wdata_i(wd_blue),
    .raddr_i(bin_b_i), .rdata_o(rd_blue)
  );

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    last_d    = last_q;
    sel_ok_d  = sel_ok_q;
    bin_r_d   = bin_r_q;
    bin_g_d   = bin_g_q;
    bin_b_d   = bin_b_q;
    sweep_d   = sweep_q;
    report_d  = report_q;
    pixel_d   = pixel_q;
    image_d   = image_q;
    pop_o     = 1'b0;
    done_d    = 1'b0;
    gray_d    = '0;
    red_d     = '0;
    green_d   = '0;
    blue_d    = '0;
    pix_res_d = pix_res_q;
    img_res_d = img_res_q;
    we_gray   = 1'b0;
    we_red    = 1'b0;
    we_green  = 1'b0;
    we_blue   = 1'b0;
    wa_gray   = bin_r_q;
    wa_red    = bin_r_q;
    wa_green  = bin_g_q;
    wa_blue   = bin_b_q;
    wd_gray   = sat_inc(rd_gray);
    wd_red    = sat_inc(rd_red);
    wd_green  = sat_inc(rd_green);
    wd_blue   = sat_inc(rd_blue);

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          // the head's bins address the banks this cycle; latch them for the write
          pop_o    = 1'b1;
          op_d     = ctrl_i.op;
          last_d   = ctrl_i.last;
          sel_ok_d = ctrl_i.sel_ok;
          bin_r_d  = bin_r_i;
          bin_g_d  = bin_g_i;
          bin_b_d  = bin_b_i;
          case (ctrl_i.op)
            OP_ADD_GRAY, OP_ADD_RGB: state_d = S_WAIT_ADD;
            OP_READ:                 state_d = S_WAIT_READ;
            OP_CLEAR: begin
              state_d  = S_SWEEP;
              sweep_d  = '0;
              report_d = 1'b1;
              pixel_d  = '0;
              image_d  = '0;
            end
            default: begin
              done_d    = 1'b1;
              pix_res_d = RESULT_W'(pixel_q);
              img_res_d = RESULT_W'(image_q);
            end
          endcase
        end
      end
      S_WAIT_ADD: begin
        if (op_q == OP_ADD_GRAY) begin
          we_gray = 1'b1;
        end else begin
          we_red   = 1'b1;
          we_green = 1'b1;
          we_blue  = 1'b1;
        end
        pixel_d = sat_inc(pixel_q);
        if (last_q) begin
          image_d = sat_inc(image_q);
        end
        done_d    = 1'b1;
        pix_res_d = RESULT_W'(pixel_d);
        img_res_d = RESULT_W'(image_d);
        state_d   = S_IDLE;
      end
      S_WAIT_READ: begin
        if (sel_ok_q) begin
          gray_d  = RESULT_W'(rd_gray);
          red_d   = RESULT_W'(rd_red);
          green_d = RESULT_W'(rd_green);
          blue_d  = RESULT_W'(rd_blue);
        end
        done_d    = 1'b1;
        pix_res_d = RESULT_W'(pixel_q);
        img_res_d = RESULT_W'(image_q);
        state_d   = S_IDLE;
      end
      S_SWEEP: begin
        we_gray  = 1'b1;
        we_red   = 1'b1;
        we_green = 1'b1;
        we_blue  = 1'b1;
        wa_gray  = sweep_q;
        wa_red   = sweep_q;
        wa_green = sweep_q;
        wa_blue  = sweep_q;
        wd_gray  = '0;
        wd_red   = '0;
        wd_green = '0;
        wd_blue  = '0;
        sweep_d  = sweep_q + 1'b1;
        if (sweep_q == LastBin) begin
          state_d   = S_IDLE;
          report_d  = 1'b0;
          done_d    = report_q;
          pix_res_d = RESULT_W'(pixel_q);
          img_res_d = RESULT_W'(image_q);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_SWEEP;
      op_q     <= OP_NOP;
      sweep_q  <= '0;
      report_q <= 1'b0;
      pixel_q  <= '0;
      image_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      sweep_q  <= sweep_d;
      report_q <= report_d;
      pixel_q  <= pixel_d;
      image_q  <= image_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q    <= last_d;
    sel_ok_q  <= sel_ok_d;
    bin_r_q   <= bin_r_d;
    bin_g_q   <= bin_g_d;
    bin_b_q   <= bin_b_d;
    gray_q    <= gray_d;
    red_q     <= red_d;
    green_q   <= green_d;
    blue_q    <= blue_d;
    pix_res_q <= pix_res_d;
    img_res_q <= img_res_d;
  end

  assign done_o           = done_q;
  assign gray_count_o     = gray_q;
  assign red_count_o      = red_q;
  assign green_count_o    = green_q;
  assign blue_count_o     = blue_q;
  assign pixels_counted_o = pix_res_q;
  assign images_counted_o = img_res_q;

endmodule

### design/color_histogram_engine.sv
// Color histogram engine top level: front decoder, two-entry command queue, bank back end.
// An add or read passes the queue, S_IDLE and S_WAIT_ADD or S_WAIT_READ; a no-op ends in S_IDLE.
// The back end takes no new command until the read-modify-write on the bank RAMs is through;
// a clear holds the back end for a zeroing sweep of all four banks.
// Reset runs the same sweep; up to two commands queue meanwhile.
// done_o pulses for one cycle per command; the receiver cannot stall.
module color_histogram_engine #(
  parameter int BIN_COUNT        = 256,
  parameter int COUNT_WIDTH      = 32,
  parameter int SAMPLE_FRAC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [2:0]                          cfg_data_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          func_i,
  input  logic signed [che_pkg::SAMPLE_W-1:0] sample_gray_or_red_i,
  input  logic signed [che_pkg::SAMPLE_W-1:0] sample_green_i,
  input  logic signed [che_pkg::SAMPLE_W-1:0] sample_blue_i,
  input  logic [che_pkg::SEL_W-1:0]           bin_select_i,
  input  logic                                last_pixel_i,
  output logic                                done_o,
  output logic [che_pkg::RESULT_W-1:0]        gray_count_o,
  output logic [che_pkg::RESULT_W-1:0]        red_count_o,
  output logic [che_pkg::RESULT_W-1:0]        green_count_o,
  output logic [che_pkg::RESULT_W-1:0]        blue_count_o,
  output logic [che_pkg::RESULT_W-1:0]        pixels_counted_o,
  output logic [che_pkg::RESULT_W-1:0]        images_counted_o
);
  import che_pkg::*;

  localparam int BinW   = $clog2(BIN_COUNT);
  localparam int CtrlW  = $bits(che_ctrl_t);
  localparam int QueueW = CtrlW + 3 * BinW;

  che_ctrl_t       fe_ctrl, be_ctrl;
  logic [BinW-1:0] fe_bin_r, fe_bin_g, fe_bin_b;
  logic [BinW-1:0] be_bin_r, be_bin_g, be_bin_b;
  logic [QueueW-1:0] q_head;
  logic q_full, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = q_full;

  che_front #(
    .BIN_COUNT(BIN_COUNT),
    .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_data_i,
    .func_i,
    .sample_gray_or_red_i,
    .sample_green_i,
    .sample_blue_i,
    .bin_select_i,
    .last_pixel_i,
    .ctrl_o(fe_ctrl),
    .bin_r_o(fe_bin_r),
    .bin_g_o(fe_bin_g),
    .bin_b_o(fe_bin_b)
  );

  che_fifo #(
    .WIDTH(QueueW),
    .DEPTH(2)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i(start_i && !busy_o),
    .data_i({fe_ctrl, fe_bin_r, fe_bin_g, fe_bin_b}),
    .pop_i(q_pop),
    .data_o(q_head),
    .full_o(q_full),
    .empty_o(q_empty)
  );

  assign {be_ctrl, be_bin_r, be_bin_g, be_bin_b} = q_head;

  che_back #(
    .BIN_COUNT(BIN_COUNT),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .empty_i(q_empty),
    .ctrl_i(be_ctrl),
    .bin_r_i(be_bin_r),
    .bin_g_i(be_bin_g),
    .bin_b_i(be_bin_b),
    .pop_o(q_pop),
    .done_o,
    .gray_count_o,
    .red_count_o,
    .green_count_o,
    .blue_count_o,
    .pixels_counted_o,
    .images_counted_o
  );

endmodule

### bench/tb_color_histogram_engine.sv
// Self-checking bench for color_histogram_engine: directed and random pixel requests
// across channel settings, scored against a bit-exact histogram predictor.
// Depends on design/che_pkg.sv and design/color_histogram_engine.sv.

typedef struct packed {
  logic [1:0]         func;
  logic signed [15:0] gray_red;
  logic signed [15:0] green;
  logic signed [15:0] blue;
  logic [7:0]         sel;
  logic               last;
} pixel_req_t;

typedef struct packed {
  logic [31:0] gray;
  logic [31:0] red;
  logic [31:0] green;
  logic [31:0] blue;
  logic [31:0] pixels;
  logic [31:0] images;
} count_set_t;

class histo_predictor;
  logic [31:0] gray_bank [256];
  logic [31:0] red_bank [256];
  logic [31:0] green_bank [256];
  logic [31:0] blue_bank [256];
  logic [31:0] pixel_total;
  logic [31:0] image_total;
  logic [2:0]  channels;
  count_set_t  expected_counts [$];
  int          errors;

  function new();
    clear_banks();
    channels = che_pkg::CHAN_RESET;
    errors   = 0;
  endfunction

  function void clear_banks();
    for (int i = 0; i < 256; i++) begin
      gray_bank[i]  = '0;
      red_bank[i]   = '0;
      green_bank[i] = '0;
      blue_bank[i]  = '0;
    end
    pixel_total = '0;
    image_total = '0;
  endfunction

  function void set_channels(logic [2:0] value);
    channels = value;
  endfunction

  // Scale by 255 in Q3.12, floor, clamp to the bin range
  function logic [7:0] bin_of(logic signed [15:0] s);
    longint scaled;
    scaled = longint'(s) * 255;
    if (scaled <= 0) return 8'd0;
    if ((scaled >>> 12) > 255) return 8'd255;
    return 8'(scaled >>> 12);
  endfunction

  function logic [31:0] bump(logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  function int pending();
    return expected_counts.size();
  endfunction

  function void note_request(pixel_req_t r);
    count_set_t e;
    bit         counted;
    e       = '0;
    counted = 1'b0;
    case (r.func)
      che_pkg::FUNC_ADD: begin
        if (channels == che_pkg::CHAN_GRAY) begin
          gray_bank[bin_of(r.gray_red)] = bump(gray_bank[bin_of(r.gray_red)]);
          counted = 1'b1;
        end else if (channels == che_pkg::CHAN_RGB) begin
          red_bank[bin_of(r.gray_red)] = bump(red_bank[bin_of(r.gray_red)]);
          green_bank[bin_of(r.green)]  = bump(green_bank[bin_of(r.green)]);
          blue_bank[bin_of(r.blue)]    = bump(blue_bank[bin_of(r.blue)]);
          counted = 1'b1;
        end
        if (counted) begin
          pixel_total = bump(pixel_total);
          if (r.last) image_total = bump(image_total);
        end
      end
      che_pkg::FUNC_READ: begin
        e.gray  = gray_bank[r.sel];
        e.red   = red_bank[r.sel];
        e.green = green_bank[r.sel];
        e.blue  = blue_bank[r.sel];
      end
      che_pkg::FUNC_CLEAR: clear_banks();
      default: ;
    endcase
    e.pixels = pixel_total;
    e.images = image_total;
    expected_counts = {expected_counts, e};
  endfunction

  function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(count_set_t got);
    count_set_t e;
    if (expected_counts.size() == 0) begin
      $error("result with no request outstanding");
      errors++;
      return;
    end
    e = expected_counts.pop_front();
    compare_field("gray_count", e.gray, got.gray);
    compare_field("red_count", e.red, got.red);
    compare_field("green_count", e.green, got.green);
    compare_field("blue_count", e.blue, got.blue);
    compare_field("pixels_counted", e.pixels, got.pixels);
    compare_field("images_counted", e.images, got.images);
  endfunction
endclass

module tb_color_histogram_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import che_pkg::*;

  localparam int TARGET_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 1000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_data_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         func_i = FUNC_NOP;
  logic signed [15:0] sample_gray_or_red_i = '0;
  logic signed [15:0] sample_green_i = '0;
  logic signed [15:0] sample_blue_i = '0;
  logic [7:0]         bin_select_i = '0;
  logic               last_pixel_i = 1'b0;
  logic               done_o;
  logic [31:0]        gray_count_o;
  logic [31:0]        red_count_o;
  logic [31:0]        green_count_o;
  logic [31:0]        blue_count_o;
  logic [31:0]        pixels_counted_o;
  logic [31:0]        images_counted_o;

  histo_predictor pred = new();
  int             cycle_count = 0;
  bit             no_gaps = 1'b0;
  logic [7:0]     recent_bin = '0;

  color_histogram_engine i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .start_i,
    .busy_o,
    .func_i,
    .sample_gray_or_red_i,
    .sample_green_i,
    .sample_blue_i,
    .bin_select_i,
    .last_pixel_i,
    .done_o,
    .gray_count_o,
    .red_count_o,
    .green_count_o,
    .blue_count_o,
    .pixels_counted_o,
    .images_counted_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sample results mid-cycle, away from the edge that changes them
  always @(negedge clk_i) begin : result_monitor
    count_set_t got;
    if (rst_ni && done_o) begin
      got.gray   = gray_count_o;
      got.red    = red_count_o;
      got.green  = green_count_o;
      got.blue   = blue_count_o;
      got.pixels = pixels_counted_o;
      got.images = images_counted_o;
      pred.check_result(got);
    end
  end

  // Called at a rising edge; returns at the edge that accepts the request
  task automatic send_request(input pixel_req_t r);
    int gap;
    bit taken;
    gap   = no_gaps ? 0 : $urandom_range(0, 3);
    taken = 1'b0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i              <= 1'b1;
    func_i               <= r.func;
    sample_gray_or_red_i <= r.gray_red;
    sample_green_i       <= r.green;
    sample_blue_i        <= r.blue;
    bin_select_i         <= r.sel;
    last_pixel_i         <= r.last;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy_o;
      if (taken) pred.note_request(r);
      @(posedge clk_i);
    end
  endtask

  task automatic issue(input logic [1:0] f, input int g, input int gr, input int b,
                       input int sel, input bit last);
    pixel_req_t r;
    r.func     = f;
    r.gray_red = 16'(g);
    r.green    = 16'(gr);
    r.blue     = 16'(b);
    r.sel      = 8'(sel);
    r.last     = last;
    send_request(r);
  endtask

  // Hold off until every result is back, then let the pipeline settle
  task automatic drain();
    start_i <= 1'b0;
    while (pred.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_channels(input logic [2:0] value);
    bit taken;
    drain();
    taken       = 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    pred.set_channels(value);
  endtask

  function automatic logic [15:0] pick_sample();
    logic [15:0] edges [9];
    edges = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'd16, 16'd17,
              16'd4095, 16'd4096, 16'h7FFF};
    case ($urandom_range(0, 9))
      0:       return edges[$urandom_range(0, 8)];
      1:       return 16'($urandom);
      default: return 16'($urandom_range(0, 4200));
    endcase
  endfunction

  function automatic pixel_req_t random_request();
    pixel_req_t  r;
    int unsigned roll;
    roll       = $urandom_range(0, 99);
    r.gray_red = pick_sample();
    r.green    = pick_sample();
    r.blue     = pick_sample();
    r.last     = ($urandom_range(0, 7) == 0);
    r.sel      = ($urandom_range(0, 9) < 6) ? recent_bin : 8'($urandom);
    if (roll < 68)      r.func = FUNC_ADD;
    else if (roll < 88) r.func = FUNC_READ;
    else if (roll < 90) r.func = FUNC_CLEAR;
    else                r.func = FUNC_NOP;
    return r;
  endfunction

  function automatic logic [2:0] pick_channels();
    logic [2:0] ignored [6];
    int unsigned k;
    ignored = '{3'd0, 3'd2, 3'd4, 3'd5, 3'd6, 3'd7};
    k = $urandom_range(0, 9);
    if (k < 4) return CHAN_GRAY;
    if (k < 8) return CHAN_RGB;
    return ignored[$urandom_range(0, 5)];
  endfunction

  initial begin : stimulus
    pixel_req_t r;
    logic [2:0] chan;
    int         work_done;
    int         burst;
    bit         ignoring;
    work_done = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Gray mode straight out of reset: bin edges and clamping
    issue(FUNC_ADD, -32768, 0, 0, 0, 1'b0);
    issue(FUNC_ADD, -1, 0, 0, 0, 1'b0);
    issue(FUNC_ADD, 0, 0, 0, 0, 1'b0);
    issue(FUNC_ADD, 1, 0, 0, 0, 1'b0);
    issue(FUNC_ADD, 16, 0, 0, 0, 1'b0);
    issue(FUNC_ADD, 17, 0, 0, 0, 1'b0);
    issue(FUNC_ADD, 4095, 0, 0, 0, 1'b1);
    issue(FUNC_ADD, 4096, 0, 0, 0, 1'b0);
    issue(FUNC_ADD, 32767, 0, 0, 0, 1'b1);
    issue(FUNC_READ, 0, 0, 0, 0, 1'b0);
    issue(FUNC_READ, 0, 0, 0, 1, 1'b0);
    issue(FUNC_READ, 0, 0, 0, 254, 1'b0);
    issue(FUNC_READ, 0, 0, 0, 255, 1'b0);
    issue(FUNC_NOP, 0, 0, 0, 0, 1'b1);
    issue(FUNC_CLEAR, 0, 0, 0, 0, 1'b0);
    issue(FUNC_READ, 0, 0, 0, 255, 1'b0);
    write_channels(CHAN_RGB);
    issue(FUNC_ADD, 32767, -32768, 4096, 0, 1'b1);
    issue(FUNC_ADD, 17, 4095, 0, 0, 1'b0);
    issue(FUNC_READ, 0, 0, 0, 255, 1'b0);
    issue(FUNC_READ, 0, 0, 0, 0, 1'b0);
    // Ignored channel counts: adds and their last marks must not count
    write_channels(3'd0);
    issue(FUNC_ADD, 4096, 4096, 4096, 0, 1'b1);
    issue(FUNC_READ, 0, 0, 0, 255, 1'b0);
    write_channels(3'd7);
    issue(FUNC_ADD, 4095, 4095, 4095, 0, 1'b1);
    issue(FUNC_NOP, 0, 0, 0, 0, 1'b0);
    issue(FUNC_READ, 0, 0, 0, 254, 1'b0);

    while (work_done < TARGET_ITEMS) begin
      chan     = pick_channels();
      ignoring = (chan != CHAN_GRAY) && (chan != CHAN_RGB);
      write_channels(chan);
      no_gaps  = ($urandom_range(0, 2) == 0);
      burst    = ignoring ? 15 : 70;
      repeat (burst) begin
        r = random_request();
        if (r.func == FUNC_ADD) recent_bin = pred.bin_of(r.gray_red);
        send_request(r);
        if (!(ignoring && r.func == FUNC_ADD)) work_done++;
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### color_histogram_engine.f
design/che_pkg.sv
design/che_ram.sv
design/che_fifo.sv
design/che_front.sv
design/che_back.sv
design/color_histogram_engine.sv
bench/tb_color_histogram_engine.sv
